FILE: hw/rtl/rv32dec_pkg.sv
// ----------------------------------------------------------------------------
// rv32dec_pkg
// Types, encodings and decode tables for the RV32IM/Zicsr instruction decoder.
// ----------------------------------------------------------------------------
package rv32dec_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_MASK   = 7'h7f;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MDIV = 7'h01;
    localparam logic [6:0] F7_MRET = 7'h18;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_PRIV = 3'd0;
    localparam logic [2:0] F3_CSR_RSVD = 3'd4;
    localparam logic [2:0] F3_FENCE   = 3'd0;
    localparam logic [2:0] F3_FENCE_I = 3'd1;
    localparam logic [2:0] F3_SW      = 3'd2;

    // rs2 field of the privileged system instructions
    localparam logic [4:0] RS2_ECALL  = 5'd0;
    localparam logic [4:0] RS2_EBREAK = 5'd1;
    localparam logic [4:0] RS2_MRET   = 5'd2;

    // Slot status
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Functional units
    localparam logic [2:0] UNIT_ALU = 3'd0;
    localparam logic [2:0] UNIT_BRU = 3'd1;
    localparam logic [2:0] UNIT_LSU = 3'd2;
    localparam logic [2:0] UNIT_MUL = 3'd3;
    localparam logic [2:0] UNIT_DIV = 3'd4;
    localparam logic [2:0] UNIT_CSR = 3'd5;

    // Operand sources
    localparam logic [1:0] SRC_OFF = 2'd0;
    localparam logic [1:0] SRC_REG = 2'd1;
    localparam logic [1:0] SRC_IMM = 2'd2;

    // Operation codes
    localparam logic [5:0] OP_ILLEGAL = 6'd0;
    localparam logic [5:0] OP_LUI     = 6'd1;
    localparam logic [5:0] OP_AUIPC   = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_JALR    = 6'd4;
    localparam logic [5:0] OP_BEQ     = 6'd5;
    localparam logic [5:0] OP_BNE     = 6'd6;
    localparam logic [5:0] OP_BLT     = 6'd7;
    localparam logic [5:0] OP_BGE     = 6'd8;
    localparam logic [5:0] OP_BLTU    = 6'd9;
    localparam logic [5:0] OP_BGEU    = 6'd10;
    localparam logic [5:0] OP_LB      = 6'd11;
    localparam logic [5:0] OP_LH      = 6'd12;
    localparam logic [5:0] OP_LW      = 6'd13;
    localparam logic [5:0] OP_LBU     = 6'd14;
    localparam logic [5:0] OP_LHU     = 6'd15;
    localparam logic [5:0] OP_SB      = 6'd16;
    localparam logic [5:0] OP_SH      = 6'd17;
    localparam logic [5:0] OP_SW      = 6'd18;
    localparam logic [5:0] OP_ADDI    = 6'd19;
    localparam logic [5:0] OP_SLTI    = 6'd20;
    localparam logic [5:0] OP_SLTIU   = 6'd21;
    localparam logic [5:0] OP_XORI    = 6'd22;
    localparam logic [5:0] OP_ORI     = 6'd23;
    localparam logic [5:0] OP_ANDI    = 6'd24;
    localparam logic [5:0] OP_SLLI    = 6'd25;
    localparam logic [5:0] OP_SRLI    = 6'd26;
    localparam logic [5:0] OP_SRAI    = 6'd27;
    localparam logic [5:0] OP_ADD     = 6'd28;
    localparam logic [5:0] OP_SUB     = 6'd29;
    localparam logic [5:0] OP_MUL     = 6'd30;
    localparam logic [5:0] OP_SLL     = 6'd31;
    localparam logic [5:0] OP_MULH    = 6'd32;
    localparam logic [5:0] OP_SLT     = 6'd33;
    localparam logic [5:0] OP_MULHSU  = 6'd34;
    localparam logic [5:0] OP_SLTU    = 6'd35;
    localparam logic [5:0] OP_MULHU   = 6'd36;
    localparam logic [5:0] OP_XOR     = 6'd37;
    localparam logic [5:0] OP_DIV     = 6'd38;
    localparam logic [5:0] OP_SRL     = 6'd39;
    localparam logic [5:0] OP_SRA     = 6'd40;
    localparam logic [5:0] OP_DIVU    = 6'd41;
    localparam logic [5:0] OP_OR      = 6'd42;
    localparam logic [5:0] OP_REM     = 6'd43;
    localparam logic [5:0] OP_AND     = 6'd44;
    localparam logic [5:0] OP_REMU    = 6'd45;
    localparam logic [5:0] OP_FENCE   = 6'd46;
    localparam logic [5:0] OP_FENCE_I = 6'd47;
    localparam logic [5:0] OP_ECALL   = 6'd48;
    localparam logic [5:0] OP_EBREAK  = 6'd49;
    localparam logic [5:0] OP_MRET    = 6'd50;
    localparam logic [5:0] OP_CSRRW   = 6'd51;
    localparam logic [5:0] OP_CSRRS   = 6'd52;
    localparam logic [5:0] OP_CSRRC   = 6'd53;
    localparam logic [5:0] OP_CSRRWI  = 6'd54;
    localparam logic [5:0] OP_CSRRSI  = 6'd55;
    localparam logic [5:0] OP_CSRRCI  = 6'd56;

    // ALU sub-operations
    localparam logic [3:0] ALU_LUI     = 4'd0;
    localparam logic [3:0] ALU_AUIPC   = 4'd1;
    localparam logic [3:0] ALU_ADD     = 4'd2;
    localparam logic [3:0] ALU_SLT     = 4'd3;
    localparam logic [3:0] ALU_SLTU    = 4'd4;
    localparam logic [3:0] ALU_XOR     = 4'd5;
    localparam logic [3:0] ALU_OR      = 4'd6;
    localparam logic [3:0] ALU_AND     = 4'd7;
    localparam logic [3:0] ALU_SLL     = 4'd8;
    localparam logic [3:0] ALU_SRL     = 4'd9;
    localparam logic [3:0] ALU_SRA     = 4'd10;
    localparam logic [3:0] ALU_SUB     = 4'd11;
    localparam logic [3:0] ALU_FENCE   = 4'd12;
    localparam logic [3:0] ALU_FENCE_I = 4'd13;
    localparam logic [3:0] ALU_ECALL   = 4'd14;
    localparam logic [3:0] ALU_EBREAK  = 4'd15;

    // Branch unit sub-operations
    localparam logic [3:0] BRU_JAL  = 4'd0;
    localparam logic [3:0] BRU_JALR = 4'd1;
    localparam logic [3:0] BRU_BEQ  = 4'd2;
    localparam logic [3:0] BRU_BNE  = 4'd3;
    localparam logic [3:0] BRU_BLT  = 4'd4;
    localparam logic [3:0] BRU_BGE  = 4'd5;
    localparam logic [3:0] BRU_BLTU = 4'd6;
    localparam logic [3:0] BRU_BGEU = 4'd7;
    localparam logic [3:0] BRU_MRET = 4'd8;

    // Load/store sub-operations
    localparam logic [3:0] LSU_LB  = 4'd0;
    localparam logic [3:0] LSU_LH  = 4'd1;
    localparam logic [3:0] LSU_LW  = 4'd2;
    localparam logic [3:0] LSU_LBU = 4'd3;
    localparam logic [3:0] LSU_LHU = 4'd4;
    localparam logic [3:0] LSU_SB  = 4'd5;
    localparam logic [3:0] LSU_SH  = 4'd6;
    localparam logic [3:0] LSU_SW  = 4'd7;

    // CSR sub-operations, shared by the immediate forms
    localparam logic [3:0] CSR_RW = 4'd0;
    localparam logic [3:0] CSR_RS = 4'd1;
    localparam logic [3:0] CSR_RC = 4'd2;

    typedef struct packed {
        logic        slot_enable;
        logic [31:0] instruction;
        logic        fetch_fault;
    } t_dec_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  op_code;
        logic [2:0]  unit;
        logic [3:0]  sub_op;
        logic [1:0]  arg1_source;
        logic [1:0]  arg2_source;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [4:0]  dest_reg;
        logic [31:0] immediate;
        logic [11:0] csr_address;
        logic [3:0]  reg_flags;
    } t_dec_out;

    // Shared ALU sub-operation for the funct3 of OP and OP-IMM
    function automatic logic [3:0] alu_sub(input logic [2:0] f3);
        logic [3:0] s;
        case (f3)
            3'd0:    s = ALU_ADD;
            3'd1:    s = ALU_SLL;
            3'd2:    s = ALU_SLT;
            3'd3:    s = ALU_SLTU;
            3'd4:    s = ALU_XOR;
            3'd5:    s = ALU_SRL;
            3'd6:    s = ALU_OR;
            default: s = ALU_AND;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] opimm_op(input logic [2:0] f3);
        logic [5:0] o;
        case (f3)
            3'd0:    o = OP_ADDI;
            3'd1:    o = OP_SLLI;
            3'd2:    o = OP_SLTI;
            3'd3:    o = OP_SLTIU;
            3'd4:    o = OP_XORI;
            3'd5:    o = OP_SRLI;
            3'd6:    o = OP_ORI;
            default: o = OP_ANDI;
        endcase
        return o;
    endfunction

    function automatic logic [5:0] op_op(input logic [2:0] f3);
        logic [5:0] o;
        case (f3)
            3'd0:    o = OP_ADD;
            3'd1:    o = OP_SLL;
            3'd2:    o = OP_SLT;
            3'd3:    o = OP_SLTU;
            3'd4:    o = OP_XOR;
            3'd5:    o = OP_SRL;
            3'd6:    o = OP_OR;
            default: o = OP_AND;
        endcase
        return o;
    endfunction

    function automatic logic [5:0] mdiv_op(input logic [2:0] f3);
        logic [5:0] o;
        case (f3)
            3'd0:    o = OP_MUL;
            3'd1:    o = OP_MULH;
            3'd2:    o = OP_MULHSU;
            3'd3:    o = OP_MULHU;
            3'd4:    o = OP_DIV;
            3'd5:    o = OP_DIVU;
            3'd6:    o = OP_REM;
            default: o = OP_REMU;
        endcase
        return o;
    endfunction

endpackage

FILE: hw/rtl/rv32im_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// Decodes one RV32IM/Zicsr instruction slot per cycle into micro-op fields.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     start / busy            i_item   (slot_enable, instruction, fault)
//  result    o_done (strobe)         o_result (status, op, unit, operands ...)
//
//  A beat is taken at every edge where start is high and busy is low; busy is
//  high only while reset is asserted. The slot is captured in an input
//  register, decoded combinationally and written to the result register,
//  so the result strobe follows r_in_vld and then r_out_vld; one beat per cycle.
//  Reset clears both valid flags. The receiver cannot stall, and no result is
//  ever held back.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rv32dec_pkg::t_dec_in  i_item,
    output logic                  o_done,
    output rv32dec_pkg::t_dec_out o_result
);

    rv32dec_pkg::t_dec_in  r_in;
    logic                  r_in_vld;
    rv32dec_pkg::t_dec_out r_out;
    logic                  r_out_vld;
    rv32dec_pkg::t_dec_out n_out;

    logic        accept;
    logic [31:0] w;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic        legal;
    logic        rd_en;
    rv32dec_pkg::t_dec_out dec;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign w     = r_in.instruction;
    assign opc   = w[6:0] & rv32dec_pkg::OPC_MASK;
    assign rd    = w[11:7];
    assign f3    = w[14:12];
    assign rs1   = w[19:15];
    assign rs2   = w[24:20];
    assign f7    = w[31:25];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = {w[31:12], 12'h000};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    // Main decode; fields are filled as the format uses them and cleared
    // below when the encoding turns out to be illegal.
    always_comb begin
        dec   = '0;
        legal = 1'b1;
        rd_en = 1'b0;
        case (opc)
            rv32dec_pkg::OPC_LUI: begin
                dec.op_code  = rv32dec_pkg::OP_LUI;
                dec.unit     = rv32dec_pkg::UNIT_ALU;
                dec.sub_op   = rv32dec_pkg::ALU_LUI;
                dec.immediate = imm_u;
                dec.dest_reg = rd;
                rd_en        = 1'b1;
            end
            rv32dec_pkg::OPC_AUIPC: begin
                dec.op_code  = rv32dec_pkg::OP_AUIPC;
                dec.unit     = rv32dec_pkg::UNIT_ALU;
                dec.sub_op   = rv32dec_pkg::ALU_AUIPC;
                dec.immediate = imm_u;
                dec.dest_reg = rd;
                rd_en        = 1'b1;
            end
            rv32dec_pkg::OPC_JAL: begin
                dec.op_code  = rv32dec_pkg::OP_JAL;
                dec.unit     = rv32dec_pkg::UNIT_BRU;
                dec.sub_op   = rv32dec_pkg::BRU_JAL;
                dec.immediate = imm_j;
                dec.dest_reg = rd;
                rd_en        = 1'b1;
            end
            rv32dec_pkg::OPC_JALR: begin
                dec.op_code     = rv32dec_pkg::OP_JALR;
                dec.unit        = rv32dec_pkg::UNIT_BRU;
                dec.sub_op      = rv32dec_pkg::BRU_JALR;
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.immediate   = imm_i;
                dec.dest_reg    = rd;
                rd_en           = 1'b1;
            end
            rv32dec_pkg::OPC_BRANCH: begin
                dec.unit        = rv32dec_pkg::UNIT_BRU;
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.arg2_source = rv32dec_pkg::SRC_REG;
                dec.src2_reg    = rs2;
                dec.immediate   = imm_b;
                case (f3)
                    3'd0: begin
                        dec.op_code = rv32dec_pkg::OP_BEQ;
                        dec.sub_op  = rv32dec_pkg::BRU_BEQ;
                    end
                    3'd1: begin
                        dec.op_code = rv32dec_pkg::OP_BNE;
                        dec.sub_op  = rv32dec_pkg::BRU_BNE;
                    end
                    3'd4: begin
                        dec.op_code = rv32dec_pkg::OP_BLT;
                        dec.sub_op  = rv32dec_pkg::BRU_BLT;
                    end
                    3'd5: begin
                        dec.op_code = rv32dec_pkg::OP_BGE;
                        dec.sub_op  = rv32dec_pkg::BRU_BGE;
                    end
                    3'd6: begin
                        dec.op_code = rv32dec_pkg::OP_BLTU;
                        dec.sub_op  = rv32dec_pkg::BRU_BLTU;
                    end
                    3'd7: begin
                        dec.op_code = rv32dec_pkg::OP_BGEU;
                        dec.sub_op  = rv32dec_pkg::BRU_BGEU;
                    end
                    default: legal = 1'b0;
                endcase
            end
            rv32dec_pkg::OPC_LOAD: begin
                dec.unit        = rv32dec_pkg::UNIT_LSU;
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.immediate   = imm_i;
                dec.dest_reg    = rd;
                rd_en           = 1'b1;
                case (f3)
                    3'd0: begin
                        dec.op_code = rv32dec_pkg::OP_LB;
                        dec.sub_op  = rv32dec_pkg::LSU_LB;
                    end
                    3'd1: begin
                        dec.op_code = rv32dec_pkg::OP_LH;
                        dec.sub_op  = rv32dec_pkg::LSU_LH;
                    end
                    3'd2: begin
                        dec.op_code = rv32dec_pkg::OP_LW;
                        dec.sub_op  = rv32dec_pkg::LSU_LW;
                    end
                    3'd4: begin
                        dec.op_code = rv32dec_pkg::OP_LBU;
                        dec.sub_op  = rv32dec_pkg::LSU_LBU;
                    end
                    3'd5: begin
                        dec.op_code = rv32dec_pkg::OP_LHU;
                        dec.sub_op  = rv32dec_pkg::LSU_LHU;
                    end
                    default: legal = 1'b0;
                endcase
            end
            rv32dec_pkg::OPC_STORE: begin
                dec.unit        = rv32dec_pkg::UNIT_LSU;
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.arg2_source = rv32dec_pkg::SRC_REG;
                dec.src2_reg    = rs2;
                dec.immediate   = imm_s;
                case (f3)
                    3'd0: begin
                        dec.op_code = rv32dec_pkg::OP_SB;
                        dec.sub_op  = rv32dec_pkg::LSU_SB;
                    end
                    3'd1: begin
                        dec.op_code = rv32dec_pkg::OP_SH;
                        dec.sub_op  = rv32dec_pkg::LSU_SH;
                    end
                    rv32dec_pkg::F3_SW: begin
                        dec.op_code = rv32dec_pkg::OP_SW;
                        dec.sub_op  = rv32dec_pkg::LSU_SW;
                    end
                    default: legal = 1'b0;
                endcase
            end
            rv32dec_pkg::OPC_OPIMM: begin
                dec.unit        = rv32dec_pkg::UNIT_ALU;
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.arg2_source = rv32dec_pkg::SRC_IMM;
                dec.immediate   = imm_i;
                dec.dest_reg    = rd;
                rd_en           = 1'b1;
                if (f3 == rv32dec_pkg::F3_SRL && f7 == rv32dec_pkg::F7_ALT) begin
                    dec.op_code = rv32dec_pkg::OP_SRAI;
                    dec.sub_op  = rv32dec_pkg::ALU_SRA;
                end else begin
                    dec.op_code = rv32dec_pkg::opimm_op(f3);
                    dec.sub_op  = rv32dec_pkg::alu_sub(f3);
                end
                // Shift immediates only allow the base funct7, or the alternate for srai.
                if (f3 == rv32dec_pkg::F3_SLL && f7 != rv32dec_pkg::F7_BASE) begin
                    legal = 1'b0;
                end
                if (f3 == rv32dec_pkg::F3_SRL && f7 != rv32dec_pkg::F7_BASE
                        && f7 != rv32dec_pkg::F7_ALT) begin
                    legal = 1'b0;
                end
            end
            rv32dec_pkg::OPC_OP: begin
                dec.arg1_source = rv32dec_pkg::SRC_REG;
                dec.src1_reg    = rs1;
                dec.arg2_source = rv32dec_pkg::SRC_REG;
                dec.src2_reg    = rs2;
                dec.dest_reg    = rd;
                rd_en           = 1'b1;
                dec.unit        = rv32dec_pkg::UNIT_ALU;
                if (f7 == rv32dec_pkg::F7_BASE) begin
                    dec.op_code = rv32dec_pkg::op_op(f3);
                    dec.sub_op  = rv32dec_pkg::alu_sub(f3);
                end else if (f7 == rv32dec_pkg::F7_ALT && f3 == rv32dec_pkg::F3_ADD) begin
                    dec.op_code = rv32dec_pkg::OP_SUB;
                    dec.sub_op  = rv32dec_pkg::ALU_SUB;
                end else if (f7 == rv32dec_pkg::F7_ALT && f3 == rv32dec_pkg::F3_SRL) begin
                    dec.op_code = rv32dec_pkg::OP_SRA;
                    dec.sub_op  = rv32dec_pkg::ALU_SRA;
                end else if (f7 == rv32dec_pkg::F7_MDIV) begin
                    // The low two funct3 bits select the operation within each unit.
                    dec.op_code = rv32dec_pkg::mdiv_op(f3);
                    dec.unit    = f3[2] ? rv32dec_pkg::UNIT_DIV : rv32dec_pkg::UNIT_MUL;
                    dec.sub_op  = {2'b00, f3[1:0]};
                end else begin
                    legal = 1'b0;
                end
            end
            rv32dec_pkg::OPC_FENCE: begin
                dec.unit = rv32dec_pkg::UNIT_ALU;
                if (rd == 5'd0 && rs1 == 5'd0 && f3 == rv32dec_pkg::F3_FENCE
                        && w[31:28] == 4'h0) begin
                    dec.op_code   = rv32dec_pkg::OP_FENCE;
                    dec.sub_op    = rv32dec_pkg::ALU_FENCE;
                    dec.immediate = {20'h00000, w[31:20]};
                end else if (rd == 5'd0 && rs1 == 5'd0 && f3 == rv32dec_pkg::F3_FENCE_I
                        && w[31:20] == 12'h000) begin
                    dec.op_code = rv32dec_pkg::OP_FENCE_I;
                    dec.sub_op  = rv32dec_pkg::ALU_FENCE_I;
                end else begin
                    legal = 1'b0;
                end
            end
            rv32dec_pkg::OPC_SYSTEM: begin
                if (f3 == rv32dec_pkg::F3_PRIV) begin
                    if (rd != 5'd0 || rs1 != 5'd0) begin
                        legal = 1'b0;
                    end else if (f7 == rv32dec_pkg::F7_BASE
                            && rs2 == rv32dec_pkg::RS2_ECALL) begin
                        dec.op_code = rv32dec_pkg::OP_ECALL;
                        dec.unit    = rv32dec_pkg::UNIT_ALU;
                        dec.sub_op  = rv32dec_pkg::ALU_ECALL;
                    end else if (f7 == rv32dec_pkg::F7_BASE
                            && rs2 == rv32dec_pkg::RS2_EBREAK) begin
                        dec.op_code = rv32dec_pkg::OP_EBREAK;
                        dec.unit    = rv32dec_pkg::UNIT_ALU;
                        dec.sub_op  = rv32dec_pkg::ALU_EBREAK;
                    end else if (f7 == rv32dec_pkg::F7_MRET
                            && rs2 == rv32dec_pkg::RS2_MRET) begin
                        dec.op_code = rv32dec_pkg::OP_MRET;
                        dec.unit    = rv32dec_pkg::UNIT_BRU;
                        dec.sub_op  = rv32dec_pkg::BRU_MRET;
                    end else begin
                        legal = 1'b0;
                    end
                end else if (f3 == rv32dec_pkg::F3_CSR_RSVD) begin
                    legal = 1'b0;
                end else begin
                    dec.unit        = rv32dec_pkg::UNIT_CSR;
                    dec.csr_address = w[31:20];
                    dec.dest_reg    = rd;
                    rd_en           = 1'b1;
                    case (f3)
                        3'd1:    dec.op_code = rv32dec_pkg::OP_CSRRW;
                        3'd2:    dec.op_code = rv32dec_pkg::OP_CSRRS;
                        3'd3:    dec.op_code = rv32dec_pkg::OP_CSRRC;
                        3'd5:    dec.op_code = rv32dec_pkg::OP_CSRRWI;
                        3'd6:    dec.op_code = rv32dec_pkg::OP_CSRRSI;
                        default: dec.op_code = rv32dec_pkg::OP_CSRRCI;
                    endcase
                    case (f3[1:0])
                        2'd1:    dec.sub_op = rv32dec_pkg::CSR_RW;
                        2'd2:    dec.sub_op = rv32dec_pkg::CSR_RS;
                        default: dec.sub_op = rv32dec_pkg::CSR_RC;
                    endcase
                    if (f3[2]) begin
                        // Immediate forms carry zimm in the rs1 field.
                        dec.arg1_source = rv32dec_pkg::SRC_IMM;
                        dec.immediate   = {27'h0000000, rs1};
                    end else begin
                        dec.arg1_source = rv32dec_pkg::SRC_REG;
                        dec.src1_reg    = rs1;
                    end
                end
            end
            default: legal = 1'b0;
        endcase
    end

    always_comb begin
        n_out = '0;
        if (r_in.slot_enable) begin
            if (!legal) begin
                n_out.status = rv32dec_pkg::ST_INVALID;
            end else begin
                n_out        = dec;
                n_out.status = r_in.fetch_fault ? rv32dec_pkg::ST_INVALID
                                                : rv32dec_pkg::ST_VALID;
                n_out.reg_flags = {
                    rd_en && (dec.dest_reg != 5'd0),
                    (dec.arg2_source == rv32dec_pkg::SRC_REG) && (dec.src2_reg != 5'd0),
                    (dec.arg1_source == rv32dec_pkg::SRC_REG) && (dec.src1_reg != 5'd0),
                    rd_en
                };
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule
